// File: hdl/multilevel_feedback_task_scheduler_assert.svh
// Assertion macros used by the scheduler's queue controller.
`ifndef MULTILEVEL_FEEDBACK_TASK_SCHEDULER_ASSERT_SVH
`define MULTILEVEL_FEEDBACK_TASK_SCHEDULER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define MLFQ_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// A condition that must hold in the cycle after the antecedent.
`define MLFQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mlfq_pkg.sv
// Shared types and constants of the multilevel feedback task scheduler.
package mlfq_pkg;

   localparam int TASKS_DEFAULT = 16;
   localparam int LEVELS        = 5;
   localparam int LEVEL_W       = 3;
   localparam int SLICE_W       = 30;
   localparam int TASK_ID_W     = 4;
   localparam int KIND_W        = 2;
   localparam int CSR_ADDR_W    = 5;
   localparam int CSR_DATA_W    = 32;

   localparam logic [LEVEL_W-1:0] LOWEST_LEVEL = 3'd4;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_NEW   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_YIELD = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

   // Reset values of the per-level slice registers.
   localparam logic [SLICE_W-1:0] SLICE_RESET [LEVELS] = '{
      30'd10000000, 30'd20000000, 30'd40000000, 30'd80000000, 30'd160000000
   };

   typedef struct packed {
      logic [KIND_W-1:0]    kind;
      logic [TASK_ID_W-1:0] task_id;
   } req_type;

   typedef struct packed {
      logic [TASK_ID_W-1:0] run_task;
      logic [LEVEL_W-1:0]   run_level;
      logic [SLICE_W-1:0]   slice_length;
      logic                 idle;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_FINISH
   } state_type;

endpackage

// File: hdl/multilevel_feedback_task_scheduler.sv
// Sequencing: an event transfer is taken in the idle state; its result is loaded in the finish state.
// No new event is taken until the finish state is left, set by the registered read of the link memory
// that yields a level's next head; a stalled result holds the following event in the
// finish state, and no further event is taken until the stalled result leaves.
// Reset clears the slice registers to their defaults, empties all five queues and
// leaves nothing running; the link memory is not cleared and needs no clearing pass.
module multilevel_feedback_task_scheduler
   import mlfq_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int TW = $clog2(TASKS);

   logic [SLICE_W-1:0] slice_ff [LEVELS];
   logic [LEVEL_W-1:0] csr_index;
   logic               csr_write;

   logic               mem_wr_en;
   logic [TW-1:0]      mem_wr_addr;
   logic [TW-1:0]      mem_wr_data;
   logic               mem_rd_en;
   logic [TW-1:0]      mem_rd_addr;
   logic [TW-1:0]      mem_rd_data;

   assign csr_index  = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Slice registers, written in the access phase of a transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            slice_ff[lv] <= SLICE_RESET[lv];
         end
      end else begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            if (csr_write && (csr_index == LEVEL_W'(lv))) begin
               slice_ff[lv] <= csr_pwdata[SLICE_W-1:0];
            end
         end
      end
   end

   // Read data; addresses past the last register read as zero.
   always_comb begin
      csr_prdata = '0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (csr_index == LEVEL_W'(lv)) begin
            csr_prdata = CSR_DATA_W'(slice_ff[lv]);
         end
      end
   end

   mlfq_ctrl #(
      .TASKS (TASKS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .slice_regs  (slice_ff),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   mlfq_link_mem #(
      .TASKS (TASKS)
   ) u_link_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

// File: hdl/mlfq_link_mem.sv
// Link memory: next-task pointer of every queued task, one write and one read port.
module mlfq_link_mem
   import mlfq_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(TASKS)-1:0]   wr_addr,
   input  logic [$clog2(TASKS)-1:0]   wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(TASKS)-1:0]   rd_addr,
   output logic [$clog2(TASKS)-1:0]   rd_data
);

   localparam int TW = $clog2(TASKS);

   logic [TW-1:0] mem [TASKS];
   logic [TW-1:0] rd_data_ff;

   // Synchronous write; registered read returns the old entry on a collision.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/mlfq_ctrl.sv
// Queue controller: level heads and tails, running task, sequencer and result register.
module mlfq_ctrl
   import mlfq_pkg::*;
#(
   parameter int TASKS = TASKS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic [SLICE_W-1:0]         slice_regs [LEVELS],
   output logic                       mem_wr_en,
   output logic [$clog2(TASKS)-1:0]   mem_wr_addr,
   output logic [$clog2(TASKS)-1:0]   mem_wr_data,
   output logic                       mem_rd_en,
   output logic [$clog2(TASKS)-1:0]   mem_rd_addr,
   input  logic [$clog2(TASKS)-1:0]   mem_rd_data
);

`include "multilevel_feedback_task_scheduler_assert.svh"

   localparam int TW = $clog2(TASKS);

   state_type          state_ff, state_in;
   logic               run_valid_ff, run_valid_in;
   logic [TW-1:0]      run_task_ff, run_task_in;
   logic [LEVEL_W-1:0] run_level_ff, run_level_in;
   logic [TW-1:0]      head_ff [LEVELS];
   logic [TW-1:0]      head_in [LEVELS];
   logic [TW-1:0]      tail_ff [LEVELS];
   logic [TW-1:0]      tail_in [LEVELS];
   logic [LEVELS-1:0]  ne_ff, ne_in;
   logic [TASKS-1:0]   link_valid_ff, link_valid_in;
   logic               pend_rd_ff, pend_rd_in;
   logic [LEVEL_W-1:0] pend_lvl_ff, pend_lvl_in;
   logic               pend_fwd_ff, pend_fwd_in;
   logic [TW-1:0]      pend_fwd_data_ff, pend_fwd_data_in;
   logic               pend_wr_ff, pend_wr_in;
   logic [TW-1:0]      pend_wr_addr_ff, pend_wr_addr_in;
   logic [TW-1:0]      pend_wr_data_ff, pend_wr_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   // Planned update for the event at the request port.
   logic               p_run_valid;
   logic [TW-1:0]      p_run_task;
   logic [LEVEL_W-1:0] p_run_level;
   logic [TW-1:0]      p_head [LEVELS];
   logic [TW-1:0]      p_tail [LEVELS];
   logic [LEVELS-1:0]  p_ne;
   logic [TASKS-1:0]   p_link_valid;
   logic               p_wr_en;
   logic [TW-1:0]      p_wr_addr;
   logic               p_rd_en;
   logic [TW-1:0]      p_rd_addr;
   logic [LEVEL_W-1:0] p_pend_lvl;
   logic               p_fwd;
   logic               p_pend_wr;
   logic [TW-1:0]      p_pend_wr_addr;
   logic [TW-1:0]      p_pend_wr_data;

   logic [TW-1:0]      id_idx;
   logic               id_ok;
   logic               demote;
   logic [LEVEL_W-1:0] demote_lvl;
   logic               pick_found;
   logic [LEVEL_W-1:0] pick_lvl;
   logic [TW-1:0]      pop_head;
   logic [TW-1:0]      pop_tail;

   assign id_idx = TW'(req_data.task_id);

   // A new task is taken only if its id is in range, not queued and not running.
   assign id_ok = (req_data.kind == KIND_NEW) && (int'(req_data.task_id) < TASKS) &&
                  !link_valid_ff[id_idx] && !(run_valid_ff && (run_task_ff == id_idx));

   assign demote = run_valid_ff && (id_ok || (req_data.kind == KIND_YIELD));
   assign demote_lvl = (run_level_ff >= LOWEST_LEVEL) ? LOWEST_LEVEL :
                       run_level_ff + LEVEL_W'(1);

   // Plan: demote the running task, then queue or pick the next one.
   always_comb begin
      p_run_valid    = run_valid_ff;
      p_run_task     = run_task_ff;
      p_run_level    = run_level_ff;
      p_head         = head_ff;
      p_tail         = tail_ff;
      p_ne           = ne_ff;
      p_link_valid   = link_valid_ff;
      p_wr_en        = 1'b0;
      p_wr_addr      = '0;
      p_rd_en        = 1'b0;
      p_rd_addr      = '0;
      p_pend_lvl     = '0;
      p_fwd          = 1'b0;
      p_pend_wr      = 1'b0;
      p_pend_wr_addr = '0;
      p_pend_wr_data = '0;
      pick_found     = 1'b0;
      pick_lvl       = '0;
      pop_head       = '0;
      pop_tail       = '0;

      // Append the demoted task at the tail of its new level.
      if (demote) begin
         for (int lv = 0; lv < LEVELS; lv++) begin
            if (demote_lvl == LEVEL_W'(lv)) begin
               if (ne_ff[lv]) begin
                  p_wr_en   = 1'b1;
                  p_wr_addr = tail_ff[lv];
                  p_tail[lv] = run_task_ff;
               end else begin
                  p_head[lv] = run_task_ff;
                  p_tail[lv] = run_task_ff;
                  p_ne[lv]   = 1'b1;
               end
            end
         end
         p_link_valid[run_task_ff] = 1'b1;
      end

      if (id_ok) begin
         // New task: it runs unless level 0 already holds tasks.
         if (ne_ff[0]) begin
            p_pend_wr      = 1'b1;
            p_pend_wr_addr = tail_ff[0];
            p_pend_wr_data = id_idx;
            p_tail[0]      = id_idx;
            p_link_valid[id_idx]     = 1'b1;
            p_link_valid[head_ff[0]] = 1'b0;
            p_run_task     = head_ff[0];
            if (head_ff[0] == tail_ff[0]) begin
               p_head[0] = id_idx;
            end else begin
               p_rd_en    = 1'b1;
               p_rd_addr  = head_ff[0];
               p_pend_lvl = '0;
            end
         end else begin
            p_run_task = id_idx;
         end
         p_run_level = '0;
         p_run_valid = 1'b1;
      end else if ((req_data.kind == KIND_YIELD) || (req_data.kind == KIND_END)) begin
         // Highest-priority non-empty level.
         for (int lv = LEVELS - 1; lv >= 0; lv--) begin
            if (p_ne[lv]) begin
               pick_found = 1'b1;
               pick_lvl   = LEVEL_W'(lv);
            end
         end
         for (int lv = 0; lv < LEVELS; lv++) begin
            if (pick_lvl == LEVEL_W'(lv)) begin
               pop_head = p_head[lv];
               pop_tail = p_tail[lv];
            end
         end
         p_run_valid = pick_found;
         if (pick_found) begin
            p_run_task = pop_head;
            p_run_level = pick_lvl;
            p_link_valid[pop_head] = 1'b0;
            if (pop_head == pop_tail) begin
               for (int lv = 0; lv < LEVELS; lv++) begin
                  if (pick_lvl == LEVEL_W'(lv)) begin
                     p_ne[lv] = 1'b0;
                  end
               end
            end else begin
               // The link just written in this cycle is forwarded past the memory.
               p_rd_en    = 1'b1;
               p_rd_addr  = pop_head;
               p_pend_lvl = pick_lvl;
               p_fwd      = p_wr_en && (p_wr_addr == pop_head);
            end
         end
      end
   end

   // Sequencer: take the event, then resolve the new head and load the result.
   always_comb begin
      state_in         = state_ff;
      run_valid_in     = run_valid_ff;
      run_task_in      = run_task_ff;
      run_level_in     = run_level_ff;
      head_in          = head_ff;
      tail_in          = tail_ff;
      ne_in            = ne_ff;
      link_valid_in    = link_valid_ff;
      pend_rd_in       = pend_rd_ff;
      pend_lvl_in      = pend_lvl_ff;
      pend_fwd_in      = pend_fwd_ff;
      pend_fwd_data_in = pend_fwd_data_ff;
      pend_wr_in       = pend_wr_ff;
      pend_wr_addr_in  = pend_wr_addr_ff;
      pend_wr_data_in  = pend_wr_data_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_in           = rsp_ff;
      req_ready        = 1'b0;
      mem_wr_en        = 1'b0;
      mem_wr_addr      = '0;
      mem_wr_data      = '0;
      mem_rd_en        = 1'b0;
      mem_rd_addr      = '0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in         = ST_FINISH;
               run_valid_in     = p_run_valid;
               run_task_in      = p_run_task;
               run_level_in     = p_run_level;
               head_in          = p_head;
               tail_in          = p_tail;
               ne_in            = p_ne;
               link_valid_in    = p_link_valid;
               pend_rd_in       = p_rd_en;
               pend_lvl_in      = p_pend_lvl;
               pend_fwd_in      = p_fwd;
               pend_fwd_data_in = run_task_ff;
               pend_wr_in       = p_pend_wr;
               pend_wr_addr_in  = p_pend_wr_addr;
               pend_wr_data_in  = p_pend_wr_data;
               mem_wr_en        = p_wr_en;
               mem_wr_addr      = p_wr_addr;
               mem_wr_data      = run_task_ff;
               mem_rd_en        = p_rd_en;
               mem_rd_addr      = p_rd_addr;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
               for (int lv = 0; lv < LEVELS; lv++) begin
                  if (pend_rd_ff && (pend_lvl_ff == LEVEL_W'(lv))) begin
                     head_in[lv] = pend_fwd_ff ? pend_fwd_data_ff : mem_rd_data;
                  end
               end
               mem_wr_en    = pend_wr_ff;
               mem_wr_addr  = pend_wr_addr_ff;
               mem_wr_data  = pend_wr_data_ff;
               rsp_valid_in = 1'b1;
               if (run_valid_ff) begin
                  rsp_in.run_task     = TASK_ID_W'(run_task_ff);
                  rsp_in.run_level    = run_level_ff;
                  rsp_in.slice_length = slice_regs[run_level_ff];
                  rsp_in.idle         = 1'b0;
               end else begin
                  rsp_in.run_task     = '0;
                  rsp_in.run_level    = '0;
                  rsp_in.slice_length = '0;
                  rsp_in.idle         = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         run_valid_ff  <= 1'b0;
         run_task_ff   <= '0;
         run_level_ff  <= '0;
         ne_ff         <= '0;
         link_valid_ff <= '0;
         pend_rd_ff    <= 1'b0;
         pend_wr_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int lv = 0; lv < LEVELS; lv++) begin
            head_ff[lv] <= '0;
            tail_ff[lv] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         run_valid_ff  <= run_valid_in;
         run_task_ff   <= run_task_in;
         run_level_ff  <= run_level_in;
         ne_ff         <= ne_in;
         link_valid_ff <= link_valid_in;
         pend_rd_ff    <= pend_rd_in;
         pend_wr_ff    <= pend_wr_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
      end
   end

   // Payload of the pending transfer and of the result.
   always_ff @(posedge clock) begin
      pend_lvl_ff      <= pend_lvl_in;
      pend_fwd_ff      <= pend_fwd_in;
      pend_fwd_data_ff <= pend_fwd_data_in;
      pend_wr_addr_ff  <= pend_wr_addr_in;
      pend_wr_data_ff  <= pend_wr_data_in;
      rsp_ff           <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `MLFQ_ASSERT_IMPLIES(a_running_not_queued, run_valid_ff, !link_valid_ff[run_task_ff], "running task is also queued")
   `MLFQ_ASSERT_IMPLIES(a_empty_no_waiters, ne_ff == '0, link_valid_ff == '0, "task waits while all levels are empty")
   `MLFQ_ASSERT_IMPLIES(a_idle_fields_zero, rsp_valid_ff && rsp_ff.idle, (rsp_ff.run_task == '0) && (rsp_ff.run_level == '0) && (rsp_ff.slice_length == '0), "idle result carries nonzero fields")
   `MLFQ_ASSERT_NEXT(a_finish_loads_result, (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE), "finished event gave no result")

endmodule
